/* rtl/ray_triangle_intersect_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ray / triangle intersection block
// Concurrent checks clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_INTERSECT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_MACROS_SVH

// plain property, checked every clock
`define RTI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define RTI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/rti_pkg.sv */
// ----------------------------------------------------------------------------
// rti_pkg
// Widths, register codes and shared types of the ray / triangle block.
// ----------------------------------------------------------------------------
`default_nettype none

package rti_pkg;

	localparam int COORD_W   = 32;             // Q16.16 coordinates
	localparam int DIFF_W    = COORD_W + 1;    // vertex differences
	localparam int PROD_P_W  = COORD_W + DIFF_W;
	localparam int PROD_Q_W  = DIFF_W + DIFF_W;
	localparam int CROSS_P_W = PROD_P_W + 1;   // p = dir x e1
	localparam int CROSS_Q_W = PROD_Q_W + 1;   // q = s x e0
	localparam int SPLIT_W   = 33;             // low slice of a cross term
	localparam int PP_W      = 68;             // partial product width
	localparam int ACC_W     = 104;            // det, u, v, t
	localparam int REM_W     = ACC_W + 1;
	localparam int FRAC_W    = 16;
	localparam int QUO_W     = 32;
	localparam int BARY_W    = 17;
	localparam int DIST_W    = 32;
	localparam int NUM_AXES  = 3;
	localparam int NUM_DOT   = 4;
	localparam int NUM_LANE  = 3;
	localparam int NUM_CFG   = 6;
	localparam int CFG_W     = 32;
	localparam int ADDR_W    = 5;
	localparam int IN_W      = 9 * COORD_W;
	localparam int OUT_W     = 72;             // 66 payload bits, byte padded

	localparam int DOT_DET = 0;
	localparam int DOT_U   = 1;
	localparam int DOT_V   = 2;
	localparam int DOT_T   = 3;

	localparam int LANE_U = 0;
	localparam int LANE_V = 1;
	localparam int LANE_T = 2;

	localparam int NEXT_AXIS [NUM_AXES] = '{1, 2, 0};
	localparam int PREV_AXIS [NUM_AXES] = '{2, 0, 1};

	localparam logic [DIST_W-1:0] DIST_MAX = 32'h7FFF_FFFF;
	localparam logic [DIST_W-1:0] DIST_MIN = 32'h8000_0000;
	localparam logic [BARY_W:0]   BARY_ONE = 18'd65536;

	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_DIR_X    = 3'd3,
		REG_DIR_Y    = 3'd4,
		REG_DIR_Z    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic en;
		logic vld;
	} pipe_ctl_t;

	typedef struct packed {
		logic hit;
		logic t_neg;
	} div_tag_t;

endpackage

`default_nettype wire

/* rtl/rti_vec.sv */
// ----------------------------------------------------------------------------
// rti_vec
// Six-stage vector datapath: edges, cross products and the four dot products.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_vec (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rti_pkg::pipe_ctl_t                   ctl,
	input  logic signed [rti_pkg::COORD_W-1:0]   va [rti_pkg::NUM_AXES],
	input  logic signed [rti_pkg::COORD_W-1:0]   vb [rti_pkg::NUM_AXES],
	input  logic signed [rti_pkg::COORD_W-1:0]   vc [rti_pkg::NUM_AXES],
	input  logic signed [rti_pkg::COORD_W-1:0]   org [rti_pkg::NUM_AXES],
	input  logic signed [rti_pkg::COORD_W-1:0]   dir [rti_pkg::NUM_AXES],
	output logic                                 vld_s6,
	output logic signed [rti_pkg::ACC_W-1:0]     dot_s6 [rti_pkg::NUM_DOT]
);

	import rti_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic signed [DIFF_W-1:0]    e0_s1 [NUM_AXES], e1_s1 [NUM_AXES], rel_s1 [NUM_AXES];
	logic signed [DIFF_W-1:0]    e0_s2 [NUM_AXES], e1_s2 [NUM_AXES], rel_s2 [NUM_AXES];
	logic signed [DIFF_W-1:0]    e0_s3 [NUM_AXES], e1_s3 [NUM_AXES], rel_s3 [NUM_AXES];
	logic signed [PROD_P_W-1:0]  pa_s2 [NUM_AXES], pb_s2 [NUM_AXES];
	logic signed [PROD_Q_W-1:0]  qa_s2 [NUM_AXES], qb_s2 [NUM_AXES];
	logic signed [CROSS_P_W-1:0] p_s3 [NUM_AXES];
	logic signed [CROSS_Q_W-1:0] q_s3 [NUM_AXES];
	logic signed [PP_W-1:0]      lo_s4 [NUM_DOT][NUM_AXES];
	logic signed [PP_W-1:0]      hi_s4 [NUM_DOT][NUM_AXES];
	logic signed [ACC_W-1:0]     comp_s5 [NUM_DOT][NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (ctl.en) begin
			vld_s1 <= ctl.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				// s1: edges and origin offset
				e0_s1[k]  <= DIFF_W'(vb[k]) - DIFF_W'(va[k]);
				e1_s1[k]  <= DIFF_W'(vc[k]) - DIFF_W'(va[k]);
				rel_s1[k] <= DIFF_W'(org[k]) - DIFF_W'(va[k]);
				// s2: cross product terms
				pa_s2[k] <= PROD_P_W'(dir[NEXT_AXIS[k]]) * PROD_P_W'(e1_s1[PREV_AXIS[k]]);
				pb_s2[k] <= PROD_P_W'(dir[PREV_AXIS[k]]) * PROD_P_W'(e1_s1[NEXT_AXIS[k]]);
				qa_s2[k] <= PROD_Q_W'(rel_s1[NEXT_AXIS[k]]) * PROD_Q_W'(e0_s1[PREV_AXIS[k]]);
				qb_s2[k] <= PROD_Q_W'(rel_s1[PREV_AXIS[k]]) * PROD_Q_W'(e0_s1[NEXT_AXIS[k]]);
				e0_s2[k]  <= e0_s1[k];
				e1_s2[k]  <= e1_s1[k];
				rel_s2[k] <= rel_s1[k];
				// s3: cross products
				p_s3[k]   <= CROSS_P_W'(pa_s2[k]) - CROSS_P_W'(pb_s2[k]);
				q_s3[k]   <= CROSS_Q_W'(qa_s2[k]) - CROSS_Q_W'(qb_s2[k]);
				e0_s3[k]  <= e0_s2[k];
				e1_s3[k]  <= e1_s2[k];
				rel_s3[k] <= rel_s2[k];
				// s4: cross terms split in a low unsigned and a high signed slice
				lo_s4[DOT_DET][k] <= PP_W'(signed'({1'b0, p_s3[k][SPLIT_W-1:0]}))
					* PP_W'(e0_s3[k]);
				hi_s4[DOT_DET][k] <= PP_W'(signed'(p_s3[k][CROSS_P_W-1:SPLIT_W]))
					* PP_W'(e0_s3[k]);
				lo_s4[DOT_U][k]   <= PP_W'(signed'({1'b0, p_s3[k][SPLIT_W-1:0]}))
					* PP_W'(rel_s3[k]);
				hi_s4[DOT_U][k]   <= PP_W'(signed'(p_s3[k][CROSS_P_W-1:SPLIT_W]))
					* PP_W'(rel_s3[k]);
				lo_s4[DOT_V][k]   <= PP_W'(signed'({1'b0, q_s3[k][SPLIT_W-1:0]}))
					* PP_W'(dir[k]);
				hi_s4[DOT_V][k]   <= PP_W'(signed'(q_s3[k][CROSS_Q_W-1:SPLIT_W]))
					* PP_W'(dir[k]);
				lo_s4[DOT_T][k]   <= PP_W'(signed'({1'b0, q_s3[k][SPLIT_W-1:0]}))
					* PP_W'(e1_s3[k]);
				hi_s4[DOT_T][k]   <= PP_W'(signed'(q_s3[k][CROSS_Q_W-1:SPLIT_W]))
					* PP_W'(e1_s3[k]);
			end
			// s5: rejoin slices, s6: sum the three axes
			for (int d = 0; d < NUM_DOT; d++) begin
				for (int k = 0; k < NUM_AXES; k++) begin
					comp_s5[d][k] <= (ACC_W'(hi_s4[d][k]) <<< SPLIT_W) + ACC_W'(lo_s4[d][k]);
				end
				dot_s6[d] <= comp_s5[d][0] + comp_s5[d][1] + comp_s5[d][2];
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/rti_div.sv */
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring divider, three lanes sharing one divisor, one bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              vld_in,
	input  rti_pkg::div_tag_t                 tag_in,
	input  logic [rti_pkg::ACC_W-1:0]         mag_in [rti_pkg::NUM_LANE],
	input  logic [rti_pkg::ACC_W-1:0]         den_in,
	output logic                              vld_out,
	output rti_pkg::div_tag_t                 tag_out,
	output logic [rti_pkg::QUO_W-1:0]         quo_out [rti_pkg::NUM_LANE],
	output logic                              big_out [rti_pkg::NUM_LANE]
);

	import rti_pkg::*;

	// stage 0 is the setup stage, stage QUO_W holds the finished quotient
	logic              vld_s [QUO_W+1];
	div_tag_t          tag_s [QUO_W+1];
	logic [ACC_W-1:0]  den_s [QUO_W];
	logic [QUO_W-1:0]  quo_s [QUO_W+1][NUM_LANE];
	logic              big_s [QUO_W+1][NUM_LANE];
	logic [REM_W-1:0]  rem_s [QUO_W][NUM_LANE];
	logic [QUO_W-1:0]  low_s [QUO_W][NUM_LANE];

	logic [REM_W-1:0]  shf [QUO_W][NUM_LANE];
	logic [REM_W-1:0]  nxt [QUO_W][NUM_LANE];
	logic              fit [QUO_W][NUM_LANE];

	always_comb begin
		for (int k = 0; k < QUO_W; k++) begin
			for (int l = 0; l < NUM_LANE; l++) begin
				shf[k][l] = {rem_s[k][l][REM_W-2:0], low_s[k][l][QUO_W-1]};
				fit[k][l] = shf[k][l] >= REM_W'(den_s[k]);
				nxt[k][l] = fit[k][l] ? shf[k][l] - REM_W'(den_s[k]) : shf[k][l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QUO_W; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= vld_in;
			for (int k = 0; k < QUO_W; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= tag_in;
			den_s[0] <= den_in;
			for (int l = 0; l < NUM_LANE; l++) begin
				// quotient fits in QUO_W bits only when mag / 2^16 < den
				rem_s[0][l] <= REM_W'(mag_in[l] >> FRAC_W);
				big_s[0][l] <= (mag_in[l] >> FRAC_W) >= den_in;
				low_s[0][l] <= {mag_in[l][FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}};
				quo_s[0][l] <= '0;
			end
			for (int k = 0; k < QUO_W; k++) begin
				tag_s[k+1] <= tag_s[k];
				if (k < QUO_W - 1) begin
					den_s[k+1] <= den_s[k];
				end
				for (int l = 0; l < NUM_LANE; l++) begin
					quo_s[k+1][l] <= {quo_s[k][l][QUO_W-2:0], fit[k][l]};
					big_s[k+1][l] <= big_s[k][l];
					if (k < QUO_W - 1) begin
						rem_s[k+1][l] <= nxt[k][l];
						low_s[k+1][l] <= low_s[k][l] << 1;
					end
				end
			end
		end
	end

	assign vld_out = vld_s[QUO_W];
	assign tag_out = tag_s[QUO_W];

	always_comb begin
		for (int l = 0; l < NUM_LANE; l++) begin
			quo_out[l] = quo_s[QUO_W][l];
			big_out[l] = big_s[QUO_W][l];
		end
	end

endmodule

`default_nettype wire

/* rtl/ray_triangle_intersect.sv */
// Each input passes stages 1 to 7, the divider and the output register.
// Throughput: one triangle per cycle unless stalled; the whole pipeline
// advances together. A result stalled on the output freezes every stage,
// so s_tready follows m_tready while the output register is full.
// Reset (arst_n low, asynchronous) clears all valid bits and the six ray
// registers to zero; the pipeline payload is not reset.
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Back-face-culling ray / triangle test in exact fixed point, one triangle
// a cycle unless stalled, against a ray held in registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ray_triangle_intersect_macros.svh"

module ray_triangle_intersect (
	input  logic                            clk,
	input  logic                            arst_n,
	// register port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rti_pkg::ADDR_W-1:0]      paddr,
	input  logic [rti_pkg::CFG_W-1:0]       pwdata,
	output logic [rti_pkg::CFG_W-1:0]       prdata,
	output logic                            pready,
	// triangles in
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (32 bits each)
	input  logic [rti_pkg::IN_W-1:0]        s_tdata,
	// results out
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// bary_u (17), bary_v (17), distance (32), zero padding (6)
	output logic [rti_pkg::OUT_W-1:0]       m_tdata,
	// hit
	output logic                            m_tuser
);

	import rti_pkg::*;

	// ------------------------------------------------------------------
	// Ray registers, APB writes complete in the access phase
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] cfg_q [NUM_CFG];
	logic [2:0]       cfg_idx;
	logic             cfg_wr;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (cfg_wr && (cfg_idx <= 3'(REG_DIR_Z))) begin
			cfg_q[cfg_idx] <= pwdata;
		end
	end

	assign prdata = (cfg_idx <= 3'(REG_DIR_Z)) ? cfg_q[cfg_idx] : '0;

	// ------------------------------------------------------------------
	// Global stall: everything moves when the output slot is free or drains
	// ------------------------------------------------------------------
	logic       out_vld_q;
	logic       pipe_en;
	pipe_ctl_t  vec_ctl;

	assign pipe_en  = m_tready || !out_vld_q;
	assign s_tready = pipe_en;
	assign vec_ctl  = '{en: pipe_en, vld: s_tvalid};

	logic signed [COORD_W-1:0] va [NUM_AXES], vb [NUM_AXES], vc [NUM_AXES];
	logic signed [COORD_W-1:0] org [NUM_AXES], dir [NUM_AXES];

	always_comb begin
		for (int k = 0; k < NUM_AXES; k++) begin
			va[k]  = signed'(s_tdata[k*COORD_W +: COORD_W]);
			vb[k]  = signed'(s_tdata[(k+NUM_AXES)*COORD_W +: COORD_W]);
			vc[k]  = signed'(s_tdata[(k+2*NUM_AXES)*COORD_W +: COORD_W]);
			org[k] = signed'(cfg_q[32'(REG_ORIGIN_X) + k]);
			dir[k] = signed'(cfg_q[32'(REG_DIR_X) + k]);
		end
	end

	// stages 1..6: det, u, v, t
	logic                    vld_s6;
	logic signed [ACC_W-1:0] dot_s6 [NUM_DOT];

	rti_vec u_vec (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (vec_ctl),
		.va     (va),
		.vb     (vb),
		.vc     (vc),
		.org    (org),
		.dir    (dir),
		.vld_s6 (vld_s6),
		.dot_s6 (dot_s6)
	);

	// ------------------------------------------------------------------
	// Stage 7: accept / reject and magnitudes for the divider.
	// Reject when det <= 0, u < 0, u > det, v < 0 or u + v > det.
	// ------------------------------------------------------------------
	logic                    det_pos, u_ok, v_ok, t_neg;
	logic signed [ACC_W:0]   uv_sum;
	logic [ACC_W-1:0]        t_mag;

	always_comb begin
		det_pos = !dot_s6[DOT_DET][ACC_W-1] && (dot_s6[DOT_DET] != '0);
		u_ok    = !dot_s6[DOT_U][ACC_W-1] && (dot_s6[DOT_U] <= dot_s6[DOT_DET]);
		uv_sum  = (ACC_W+1)'(dot_s6[DOT_U]) + (ACC_W+1)'(dot_s6[DOT_V]);
		v_ok    = !dot_s6[DOT_V][ACC_W-1] && (uv_sum <= (ACC_W+1)'(dot_s6[DOT_DET]));
		t_neg   = dot_s6[DOT_T][ACC_W-1];
		t_mag   = t_neg ? ACC_W'(-dot_s6[DOT_T]) : ACC_W'(dot_s6[DOT_T]);
	end

	logic              vld_s7;
	div_tag_t          tag_s7;
	logic [ACC_W-1:0]  mag_s7 [NUM_LANE];
	logic [ACC_W-1:0]  det_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (pipe_en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			tag_s7         <= '{hit: det_pos && u_ok && v_ok, t_neg: t_neg};
			// u and v are only used on a hit, where both are nonnegative
			mag_s7[LANE_U] <= ACC_W'(dot_s6[DOT_U]);
			mag_s7[LANE_V] <= ACC_W'(dot_s6[DOT_V]);
			mag_s7[LANE_T] <= t_mag;
			det_s7         <= ACC_W'(dot_s6[DOT_DET]);
		end
	end

	// ------------------------------------------------------------------
	// Divider: trunc(x * 2^16 / det) for all three lanes, 33 stages
	// ------------------------------------------------------------------
	logic              div_vld;
	div_tag_t          div_tag;
	logic [QUO_W-1:0]  div_quo [NUM_LANE];
	logic              div_big [NUM_LANE];

	rti_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (pipe_en),
		.vld_in  (vld_s7),
		.tag_in  (tag_s7),
		.mag_in  (mag_s7),
		.den_in  (det_s7),
		.vld_out (div_vld),
		.tag_out (div_tag),
		.quo_out (div_quo),
		.big_out (div_big)
	);

	// ------------------------------------------------------------------
	// Output register: saturate t, zero everything on a miss
	// ------------------------------------------------------------------
	logic [DIST_W-1:0] dist_sat;
	logic              hit_q;
	logic [BARY_W-1:0] bary_u_q, bary_v_q;
	logic [DIST_W-1:0] dist_q;

	always_comb begin
		if (!div_tag.t_neg) begin
			dist_sat = (div_big[LANE_T] || div_quo[LANE_T][QUO_W-1])
				? DIST_MAX : div_quo[LANE_T];
		end else begin
			dist_sat = (div_big[LANE_T] || (div_quo[LANE_T] > DIST_MIN))
				? DIST_MIN : DIST_W'(-div_quo[LANE_T]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (pipe_en) begin
			out_vld_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			hit_q    <= div_tag.hit;
			bary_u_q <= div_tag.hit ? div_quo[LANE_U][BARY_W-1:0] : '0;
			bary_v_q <= div_tag.hit ? div_quo[LANE_V][BARY_W-1:0] : '0;
			dist_q   <= div_tag.hit ? dist_sat : '0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = hit_q;
	assign m_tdata  = {{(OUT_W-2*BARY_W-DIST_W){1'b0}}, dist_q, bary_v_q, bary_u_q};

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`RTI_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tuser, m_tdata == '0, "miss with nonzero payload")
	`RTI_ASSERT_IMP(a_bary_sum, m_tvalid && m_tuser, ((BARY_W+1)'(bary_u_q) + (BARY_W+1)'(bary_v_q)) <= BARY_ONE, "u + v above one")
	`RTI_ASSERT(a_backpressure, !(m_tvalid && !m_tready && s_tready), "input taken while output stalled")

endmodule

`default_nettype wire
